[rtl/core/ctsh_pkg.sv]
`default_nettype none

package ctsh_pkg;

  localparam int NumHashTypes = 5;
  localparam int SectionWords = 32'h100;
  localparam int TableWords   = NumHashTypes * SectionWords;
  localparam int AddrW        = $clog2(TableWords);

  localparam int KeyW      = 8;
  localparam int HashTypeW = 3;
  localparam int WordW     = 32;

  localparam int QueueDepth = 2;
  localparam int QueuePtrW  = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int QueueCntW  = $clog2(QueueDepth + 1);

  localparam logic [WordW-1:0] SeedAInit = 32'h7FED7FED;
  localparam logic [WordW-1:0] SeedBInit = 32'hEEEEEEEE;
  localparam logic [WordW-1:0] SeedBInc  = 32'd3;

  localparam logic [WordW-1:0] LcgStart = 32'h00100001;
  localparam logic [WordW-1:0] LcgMul   = 32'd125;
  localparam logic [WordW-1:0] LcgInc   = 32'd3;
  localparam logic [WordW-1:0] LcgMod   = 32'h002AAAAB;
  localparam logic [WordW-1:0] LcgMask  = 32'h0000FFFF;

  localparam logic [KeyW-1:0] CharLowerA = 8'h61;
  localparam logic [KeyW-1:0] CharLowerZ = 8'h7A;
  localparam logic [KeyW-1:0] CaseOffset = 8'h20;

  typedef struct packed {
    logic [KeyW-1:0]  ch;
    logic [AddrW-1:0] addr;
    logic             in_range;
    logic             mix;
    logic             last;
  } item_t;

  function automatic logic [TableWords-1:0][WordW-1:0] fill_crypt_table();
    logic [TableWords-1:0][WordW-1:0] tab;
    logic [WordW-1:0]                 lcg;
    logic [WordW-1:0]                 hi;
    logic [WordW-1:0]                 lo;
    tab = '0;
    lcg = LcgStart;
    for (int col = 0; col < SectionWords; col++) begin
      for (int sec = 0; sec < NumHashTypes; sec++) begin
        lcg = (lcg * LcgMul + LcgInc) % LcgMod;
        hi  = (lcg & LcgMask) << 16;
        lcg = (lcg * LcgMul + LcgInc) % LcgMod;
        lo  = lcg & LcgMask;
        tab[sec * SectionWords + col] = hi | lo;
      end
    end
    return tab;
  endfunction

  localparam logic [TableWords-1:0][WordW-1:0] CryptTable = fill_crypt_table();

endpackage

`default_nettype wire

[rtl/core/ctsh_front.sv]
`default_nettype none

module ctsh_front (
  input  wire logic [ctsh_pkg::KeyW-1:0]      key_byte_i,
  input  wire logic                           byte_valid_i,
  input  wire logic [ctsh_pkg::HashTypeW-1:0] hash_type_i,
  input  wire logic                           last_i,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  output logic                                push_valid_o,
  output ctsh_pkg::item_t                     push_item_o,
  input  wire logic                           push_ready_i
);

  logic [ctsh_pkg::KeyW-1:0] ch_up;
  logic                      type_ok;

  always_comb begin
    ch_up = key_byte_i;
    if (key_byte_i >= ctsh_pkg::CharLowerA && key_byte_i <= ctsh_pkg::CharLowerZ) begin
      ch_up = key_byte_i - ctsh_pkg::CaseOffset;
    end
  end

  assign type_ok = ({1'b0, hash_type_i} < (ctsh_pkg::HashTypeW + 1)'(ctsh_pkg::NumHashTypes));

  always_comb begin
    push_item_o.ch       = ch_up;
    push_item_o.addr     = ctsh_pkg::AddrW'({hash_type_i, ch_up});
    push_item_o.in_range = type_ok;
    push_item_o.mix      = byte_valid_i;
    push_item_o.last     = last_i;
  end

  assign push_valid_o = in_valid_i;
  assign in_ready_o   = push_ready_i;

endmodule

`default_nettype wire

[rtl/core/ctsh_queue.sv]
`default_nettype none

module ctsh_queue (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push_valid_i,
  input  ctsh_pkg::item_t push_item_i,
  output logic            push_ready_o,
  output logic            pop_valid_o,
  output ctsh_pkg::item_t pop_item_o,
  input  wire logic       pop_ready_i
);

  ctsh_pkg::item_t                    mem_q [ctsh_pkg::QueueDepth];
  logic [ctsh_pkg::QueuePtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [ctsh_pkg::QueuePtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [ctsh_pkg::QueueCntW-1:0]     cnt_q, cnt_d;
  logic                               push, pop;

  assign push_ready_o = (cnt_q != ctsh_pkg::QueueCntW'(ctsh_pkg::QueueDepth));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_item_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == ctsh_pkg::QueuePtrW'(ctsh_pkg::QueueDepth - 1)) ?
                 '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == ctsh_pkg::QueuePtrW'(ctsh_pkg::QueueDepth - 1)) ?
                 '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

`default_nettype wire

[rtl/core/ctsh_back.sv]
`default_nettype none

module ctsh_back (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       pop_valid_i,
  input  ctsh_pkg::item_t                 pop_item_i,
  output logic                            pop_ready_o,
  output logic                            out_valid_o,
  output logic [ctsh_pkg::WordW-1:0]      hash_value_o,
  input  wire logic                       out_ready_i
);

  logic                          r_valid_q;
  ctsh_pkg::item_t               r_item_q;
  logic [ctsh_pkg::WordW-1:0]    r_word_q;
  logic [ctsh_pkg::WordW-1:0]    seed_a_q, seed_a_d;
  logic [ctsh_pkg::WordW-1:0]    seed_b_q, seed_b_d;
  logic [ctsh_pkg::WordW-1:0]    mix_a, mix_b;
  logic                          out_valid_q;
  logic [ctsh_pkg::WordW-1:0]    hash_q;
  logic                          exec_fire;
  logic                          r_load;

  assign exec_fire   = r_valid_q && (!r_item_q.last || !out_valid_q || out_ready_i);
  assign r_load      = pop_valid_i && (!r_valid_q || exec_fire);
  assign pop_ready_o = !r_valid_q || exec_fire;

  assign mix_a = r_word_q ^ (seed_a_q + seed_b_q);
  assign mix_b = ctsh_pkg::WordW'(r_item_q.ch) + mix_a + seed_b_q + (seed_b_q << 5)
               + ctsh_pkg::SeedBInc;

  always_comb begin
    seed_a_d = seed_a_q;
    seed_b_d = seed_b_q;
    if (exec_fire) begin
      if (r_item_q.last) begin
        seed_a_d = ctsh_pkg::SeedAInit;
        seed_b_d = ctsh_pkg::SeedBInit;
      end else if (r_item_q.mix) begin
        seed_a_d = mix_a;
        seed_b_d = mix_b;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
      seed_a_q    <= ctsh_pkg::SeedAInit;
      seed_b_q    <= ctsh_pkg::SeedBInit;
    end else begin
      seed_a_q <= seed_a_d;
      seed_b_q <= seed_b_d;
      if (r_load) begin
        r_valid_q <= 1'b1;
      end else if (exec_fire) begin
        r_valid_q <= 1'b0;
      end
      if (exec_fire && r_item_q.last) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (r_load) begin
      r_item_q <= pop_item_i;
      r_word_q <= pop_item_i.in_range ? ctsh_pkg::CryptTable[pop_item_i.addr] : '0;
    end
    if (exec_fire && r_item_q.last) begin
      hash_q <= r_item_q.mix ? mix_a : seed_a_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign hash_value_o = hash_q;

endmodule

`default_nettype wire

[rtl/core/crypt_table_string_hash.sv]
`default_nettype none

// Streaming one-way string hash over a 1280-word crypt table. One key byte
// enters per item and items are taken at one per cycle while the output is
// not stalled; the hash of a key passes through the queue, the table read
// register and the result register after its last item is accepted and
// waits on hash_value_o until taken. The rate is set by the seed update, a
// recurrence fed by the registered read of the crypt table ROM; a two-entry
// queue between classifier and table/mix pipeline lets either side stall.
module crypt_table_string_hash (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic [ctsh_pkg::KeyW-1:0]      key_byte_i,
  input  wire logic                           byte_valid_i,
  input  wire logic [ctsh_pkg::HashTypeW-1:0] hash_type_i,
  input  wire logic                           last_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic [ctsh_pkg::WordW-1:0]          hash_value_o
);

  logic            push_valid, push_ready;
  ctsh_pkg::item_t push_item;
  logic            pop_valid, pop_ready;
  ctsh_pkg::item_t pop_item;

  ctsh_front u_front (
    .key_byte_i   (key_byte_i),
    .byte_valid_i (byte_valid_i),
    .hash_type_i  (hash_type_i),
    .last_i       (last_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .push_valid_o (push_valid),
    .push_item_o  (push_item),
    .push_ready_i (push_ready)
  );

  ctsh_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_item_i  (push_item),
    .push_ready_o (push_ready),
    .pop_valid_o  (pop_valid),
    .pop_item_o   (pop_item),
    .pop_ready_i  (pop_ready)
  );

  ctsh_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .pop_valid_i  (pop_valid),
    .pop_item_i   (pop_item),
    .pop_ready_o  (pop_ready),
    .out_valid_o  (out_valid_o),
    .hash_value_o (hash_value_o),
    .out_ready_i  (out_ready_i)
  );

endmodule

`default_nettype wire

[rtl/core/ctsh_checker.sv]
`default_nettype none

module ctsh_checker (
  input wire logic                           clk_i,
  input wire logic                           rst_ni,
  input wire logic                           in_valid_i,
  input wire logic                           in_ready_o,
  input wire logic [ctsh_pkg::KeyW-1:0]      key_byte_i,
  input wire logic                           byte_valid_i,
  input wire logic [ctsh_pkg::HashTypeW-1:0] hash_type_i,
  input wire logic                           last_i,
  input wire logic                           out_valid_o,
  input wire logic                           out_ready_i,
  input wire logic [ctsh_pkg::WordW-1:0]     hash_value_o
);

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=>
      in_valid_i && $stable({key_byte_i, byte_valid_i, hash_type_i, last_i}))
    else $error("input item changed while stalled");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result item dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(hash_value_o))
    else $error("hash value changed while stalled");

  a_full_only_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input blocked with no result pending");

  a_ready_recovers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |=> in_ready_o || out_valid_o)
    else $error("pipeline failed to drain with output free");

endmodule

bind crypt_table_string_hash ctsh_checker u_ctsh_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .key_byte_i   (key_byte_i),
  .byte_valid_i (byte_valid_i),
  .hash_type_i  (hash_type_i),
  .last_i       (last_i),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .hash_value_o (hash_value_o)
);

`default_nettype wire
